>>> rtl/xfast_trie_predecessor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the x-fast trie predecessor block.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef XFAST_TRIE_PREDECESSOR_MACROS_SVH
`define XFAST_TRIE_PREDECESSOR_MACROS_SVH
`ifndef SYNTHESIS
`define XFTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xftp: assertion failed");
`define XFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xftp: assertion failed");
`else
`define XFTP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define XFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/xftp_pkg.sv
// ----------------------------------------------------------------------------
// xftp_pkg
// Shared widths, operation codes, datapath commands and status.
// ----------------------------------------------------------------------------
package xftp_pkg;

	localparam int KEY_LEN_DEF      = 16;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int KEY_W            = 16;
	localparam int PAY_W            = 32;
	localparam int PROBE_W          = 4;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_FIND   = 2'd1;
	localparam mode_t MODE_PRED   = 2'd2;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_CLR,
		OP_LOAD,
		OP_LEAF_RD,
		OP_PROBE_RD,
		OP_PROBE_EV,
		OP_FINAL,
		OP_CAND,
		OP_PREV_EV,
		OP_SUCC_RD,
		OP_SUCC_EV,
		OP_LINK1,
		OP_LINK2,
		OP_LVL_RD,
		OP_LVL_WR,
		OP_FIND_DONE,
		OP_INS_DONE,
		OP_PRED_DONE,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		mode_t mode;
		logic  in_range;
		logic  empty;
		logic  present;
		logic  srch_done;
		logic  cand_ge;
		logic  p_valid;
		logic  lvl_last;
		logic  clr_last;
	} dp_stat_t;

endpackage

>>> rtl/xftp_in_if.sv
// ----------------------------------------------------------------------------
// xftp_in_if
// Request channel: operation, key and payload with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface xftp_in_if import xftp_pkg::*; ();
	logic               valid;
	logic               ready;
	mode_t              mode;
	logic [KEY_W-1:0]   key;
	logic [PAY_W-1:0]   payload;

	modport source (output valid, output mode, output key, output payload, input ready);
	modport sink (input valid, input mode, input key, input payload, output ready);
endinterface

>>> rtl/xftp_out_if.sv
// ----------------------------------------------------------------------------
// xftp_out_if
// Response channel: status, predecessor key, payload and probe count.
// ----------------------------------------------------------------------------
interface xftp_out_if import xftp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic [KEY_W-1:0]   result_key;
	logic [PAY_W-1:0]   result_payload;
	logic [PROBE_W-1:0] probe_count;

	modport source (output valid, output ok, output result_key, output result_payload,
		output probe_count, input ready);
	modport sink (input valid, input ok, input result_key, input result_payload,
		input probe_count, output ready);
endinterface

>>> rtl/xftp_ram.sv
// ----------------------------------------------------------------------------
// xftp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module xftp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/xftp_dpath.sv
// ----------------------------------------------------------------------------
// xftp_dpath
// Trie datapath: prefix node memory, leaf link and value memories, search
// registers and the result register.
// ----------------------------------------------------------------------------
module xftp_dpath import xftp_pkg::*; #(
	parameter int KEY_LEN      = KEY_LEN_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_op_t             op,
	input  mode_t              in_mode,
	input  logic [KEY_W-1:0]   in_key,
	input  logic [PAY_W-1:0]   in_payload,
	output dp_stat_t           stat,
	output logic               ok,
	output logic [KEY_W-1:0]   result_key,
	output logic [PAY_W-1:0]   result_payload,
	output logic [PROBE_W-1:0] probe_count
);

	localparam int NODE_AW = KEY_LEN + 1;
	localparam int LINK_W  = KEY_LEN + 1;
	localparam int NODE_W  = 2 * KEY_LEN + 1;
	localparam int LEN_W   = $clog2(KEY_LEN + 2);
	localparam int KIDX_W  = $clog2(KEY_LEN);

	typedef logic [KEY_LEN-1:0] key_t;

	// Prefix of length len sits at index {1, top len key bits}.
	function automatic logic [NODE_AW-1:0] pfx_index(input key_t k, input logic [LEN_W-1:0] len);
		logic [NODE_AW-1:0] full_k;
		full_k = {1'b1, k};
		return full_k >> (LEN_W'(KEY_LEN) - len);
	endfunction

	key_t key_cut;
	logic rng_in;

	if (KEY_LEN >= KEY_W) begin : g_wide
		assign key_cut = KEY_LEN'(in_key);
		assign rng_in  = 1'b1;
	end else begin : g_narrow
		assign key_cut = in_key[KEY_LEN-1:0];
		assign rng_in  = (in_key[KEY_W-1:KEY_LEN] == '0);
	end

	mode_t                   mode_q;
	key_t                    key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    rng_q;
	logic [LEN_W-1:0]        lo_q, hi1_q, found_q, lvl_q;
	logic [PROBE_W-1:0]      probes_q;
	key_t                    cand_q;
	logic [LINK_W-1:0]       p_q, s_q;
	logic                    ok_w_q;
	key_t                    rkey_w_q;
	logic [PAY_W-1:0]        rpay_w_q;
	logic                    empty_q;
	logic [NODE_AW-1:0]      clr_q;
	logic                    out_ok_q;
	logic [KEY_W-1:0]        out_key_q;
	logic [PAY_W-1:0]        out_pay_q;
	logic [PROBE_W-1:0]      out_probe_q;

	logic                    node_we;
	logic [NODE_AW-1:0]      node_waddr, node_raddr;
	logic [NODE_W-1:0]       node_wdata, node_rdata;
	logic                    prev_we, next_we;
	key_t                    prev_waddr, next_waddr;
	logic [LINK_W-1:0]       prev_wdata, next_wdata, prev_rdata, next_rdata;
	logic [PAYLOAD_BITS-1:0] value_rdata;

	logic                    node_present;
	key_t                    nmin, nmax;
	logic [LEN_W:0]          mid_sum;
	logic [LEN_W-1:0]        mid;
	logic [KIDX_W-1:0]       bit_idx;
	key_t                    cand_c;
	logic                    fresh;
	key_t                    new_min, new_max;

	assign node_present = node_rdata[NODE_W-1];
	assign nmin         = node_rdata[2*KEY_LEN-1:KEY_LEN];
	assign nmax         = node_rdata[KEY_LEN-1:0];

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi1_q} - (LEN_W + 1)'(1);
	assign mid     = mid_sum[LEN_W:1];

	assign bit_idx = KIDX_W'(KEY_LEN - 1) - KIDX_W'(found_q);
	assign cand_c  = (found_q == LEN_W'(KEY_LEN)) ? key_q
		: (key_q[bit_idx] ? nmax : nmin);

	assign fresh   = !node_present || ((lvl_q == '0) && empty_q);
	assign new_min = (fresh || (key_q < nmin)) ? key_q : nmin;
	assign new_max = (fresh || (key_q > nmax)) ? key_q : nmax;

	always_comb begin
		case (op)
			OP_LEAF_RD:  node_raddr = {1'b1, key_q};
			OP_PROBE_RD: node_raddr = pfx_index(key_q, mid);
			OP_FINAL:    node_raddr = pfx_index(key_q, found_q);
			OP_SUCC_RD:  node_raddr = NODE_AW'(1);
			OP_LVL_RD:   node_raddr = pfx_index(key_q, lvl_q);
			default:     node_raddr = pfx_index(key_q, lvl_q);
		endcase
	end

	assign node_we    = (op == OP_CLR) || (op == OP_LVL_WR);
	assign node_waddr = (op == OP_CLR) ? clr_q : pfx_index(key_q, lvl_q);
	assign node_wdata = (op == OP_CLR) ? {(clr_q == NODE_AW'(1)), {(2 * KEY_LEN){1'b0}}}
		: {1'b1, new_min, new_max};

	assign prev_we    = (op == OP_LINK1) || ((op == OP_LINK2) && s_q[KEY_LEN]);
	assign prev_waddr = (op == OP_LINK1) ? key_q : s_q[KEY_LEN-1:0];
	assign prev_wdata = (op == OP_LINK1) ? p_q : {1'b1, key_q};

	assign next_we    = (op == OP_LINK1) || ((op == OP_LINK2) && p_q[KEY_LEN]);
	assign next_waddr = (op == OP_LINK1) ? key_q : p_q[KEY_LEN-1:0];
	assign next_wdata = (op == OP_LINK1) ? s_q : {1'b1, key_q};

	xftp_ram #(.WIDTH(NODE_W), .DEPTH(2 ** NODE_AW)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	xftp_ram #(.WIDTH(LINK_W), .DEPTH(2 ** KEY_LEN)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(cand_q), .rdata(prev_rdata)
	);

	xftp_ram #(.WIDTH(LINK_W), .DEPTH(2 ** KEY_LEN)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(p_q[KEY_LEN-1:0]), .rdata(next_rdata)
	);

	xftp_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(2 ** KEY_LEN)) u_value_ram (
		.clk(clk), .we(op == OP_LINK1), .waddr(key_q), .wdata(payload_q),
		.raddr(p_q[KEY_LEN-1:0]), .rdata(value_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
			clr_q   <= '0;
		end else begin
			case (op)
				OP_CLR:      clr_q   <= clr_q + NODE_AW'(1);
				OP_INS_DONE: empty_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				mode_q    <= in_mode;
				key_q     <= key_cut;
				payload_q <= PAYLOAD_BITS'(in_payload);
				rng_q     <= rng_in;
				lo_q      <= '0;
				hi1_q     <= LEN_W'(KEY_LEN + 1);
				found_q   <= '0;
				lvl_q     <= '0;
				probes_q  <= '0;
				p_q       <= '0;
				s_q       <= '0;
				ok_w_q    <= 1'b0;
				rkey_w_q  <= '0;
				rpay_w_q  <= '0;
			end
			OP_PROBE_RD: probes_q <= probes_q + PROBE_W'(1);
			OP_PROBE_EV: begin
				if (node_present) begin
					found_q <= mid;
					lo_q    <= mid + LEN_W'(1);
				end else begin
					hi1_q <= mid;
				end
			end
			OP_FINAL: probes_q <= probes_q + PROBE_W'(1);
			OP_CAND: begin
				cand_q <= cand_c;
				p_q    <= {1'b1, cand_c};
			end
			OP_PREV_EV: p_q <= prev_rdata;
			OP_SUCC_EV: s_q <= p_q[KEY_LEN] ? next_rdata : {1'b1, nmin};
			OP_LVL_WR:  lvl_q <= lvl_q + LEN_W'(1);
			OP_FIND_DONE: ok_w_q <= node_present;
			OP_INS_DONE:  ok_w_q <= 1'b1;
			OP_PRED_DONE: begin
				ok_w_q   <= 1'b1;
				rkey_w_q <= p_q[KEY_LEN-1:0];
				rpay_w_q <= PAY_W'(value_rdata);
			end
			OP_EMIT: begin
				out_ok_q    <= ok_w_q;
				out_key_q   <= KEY_W'(rkey_w_q);
				out_pay_q   <= rpay_w_q;
				out_probe_q <= (mode_q == MODE_PRED) ? probes_q : '0;
			end
			default: ;
		endcase
	end

	assign stat.mode      = mode_q;
	assign stat.in_range  = rng_q;
	assign stat.empty     = empty_q;
	assign stat.present   = node_present;
	assign stat.srch_done = (lo_q >= hi1_q);
	assign stat.cand_ge   = (cand_q >= key_q);
	assign stat.p_valid   = p_q[KEY_LEN];
	assign stat.lvl_last  = (lvl_q == LEN_W'(KEY_LEN));
	assign stat.clr_last  = (clr_q == '1);

	assign ok             = out_ok_q;
	assign result_key     = out_key_q;
	assign result_payload = out_pay_q;
	assign probe_count    = out_probe_q;

endmodule

>>> rtl/xftp_ctrl.sv
// ----------------------------------------------------------------------------
// xftp_ctrl
// Sequencer: clears the prefix memory after reset, then steps transactions
// through lookup or search, and inserts through linking and level updates.
// ----------------------------------------------------------------------------
module xftp_ctrl import xftp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_op_t   op
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_LEAF_EV,
		S_SRCH,
		S_PROBE_EV,
		S_CAND,
		S_CAND_CHK,
		S_PREV_EV,
		S_AFTER,
		S_SUCC_EV,
		S_LINK1,
		S_LINK2,
		S_LVL_RD,
		S_LVL_WR,
		S_INS_DONE,
		S_VAL_EV,
		S_EMIT
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		op       = OP_IDLE;
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				op = OP_CLR;
				if (stat.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					op       = OP_LOAD;
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.in_range && (stat.mode == MODE_INSERT || stat.mode == MODE_FIND)) begin
					op       = OP_LEAF_RD;
					state_nx = S_LEAF_EV;
				end else if (stat.in_range && stat.mode == MODE_PRED) begin
					state_nx = S_SRCH;
				end else begin
					state_nx = S_EMIT;
				end
			end
			S_LEAF_EV: begin
				if (stat.mode == MODE_FIND) begin
					op       = OP_FIND_DONE;
					state_nx = S_EMIT;
				end else if (stat.present) begin
					state_nx = S_EMIT;
				end else if (stat.empty) begin
					state_nx = S_LINK1;
				end else begin
					state_nx = S_SRCH;
				end
			end
			S_SRCH: begin
				if (stat.srch_done) begin
					op       = OP_FINAL;
					state_nx = (stat.mode == MODE_PRED && stat.empty) ? S_EMIT : S_CAND;
				end else begin
					op       = OP_PROBE_RD;
					state_nx = S_PROBE_EV;
				end
			end
			S_PROBE_EV: begin
				op       = OP_PROBE_EV;
				state_nx = S_SRCH;
			end
			S_CAND: begin
				op       = OP_CAND;
				state_nx = S_CAND_CHK;
			end
			S_CAND_CHK: begin
				state_nx = stat.cand_ge ? S_PREV_EV : S_AFTER;
			end
			S_PREV_EV: begin
				op       = OP_PREV_EV;
				state_nx = S_AFTER;
			end
			S_AFTER: begin
				if (stat.mode == MODE_INSERT) begin
					op       = OP_SUCC_RD;
					state_nx = S_SUCC_EV;
				end else begin
					state_nx = stat.p_valid ? S_VAL_EV : S_EMIT;
				end
			end
			S_SUCC_EV: begin
				op       = OP_SUCC_EV;
				state_nx = S_LINK1;
			end
			S_LINK1: begin
				op       = OP_LINK1;
				state_nx = S_LINK2;
			end
			S_LINK2: begin
				op       = OP_LINK2;
				state_nx = S_LVL_RD;
			end
			S_LVL_RD: begin
				op       = OP_LVL_RD;
				state_nx = S_LVL_WR;
			end
			S_LVL_WR: begin
				op       = OP_LVL_WR;
				state_nx = stat.lvl_last ? S_INS_DONE : S_LVL_RD;
			end
			S_INS_DONE: begin
				op       = OP_INS_DONE;
				state_nx = S_EMIT;
			end
			S_VAL_EV: begin
				op       = OP_PRED_DONE;
				state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					op       = OP_EMIT;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/xfast_trie_predecessor.sv
// ----------------------------------------------------------------------------
// xfast_trie_predecessor
// X-fast trie with insert, exact find and strict predecessor search.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_ch carries a mode (insert, find or strict
// predecessor), a key and, for inserts, a payload. Exactly one transaction
// leaves on out_ch for each one taken, in order, with ok, the predecessor
// key and payload, and, for a predecessor search, the number of prefix
// memory probes. Items are worked one at a time; in_ch.ready is high only
// while the block is waiting for work. The cycle count is set by the single
// read port of the prefix node memory, which every probe and level update
// goes through. The binary search makes at most 5 probes for 16-bit keys.
// The next transaction can be taken in the cycle the result appears.
// After reset the prefix memory is swept once over every entry, one entry
// a cycle; in_ch.ready stays low throughout. The result sits in an
// output register: when out_ch stalls, the block still takes the next
// transaction and works it up to the point of delivery, then holds until
// the register is free.
// ----------------------------------------------------------------------------
`include "xfast_trie_predecessor_macros.svh"

module xfast_trie_predecessor import xftp_pkg::*; #(
	parameter int KEY_LEN      = KEY_LEN_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	xftp_in_if.sink   in_ch,
	xftp_out_if.source out_ch
);

	// Commands flow from the sequencer to the datapath; status flows back.
	dp_op_t   dp_op;
	dp_stat_t dp_stat;
	logic     in_ready;
	logic     out_valid;

	xftp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(dp_stat),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.op(dp_op)
	);

	// The datapath owns all memories and the output register.
	xftp_dpath #(.KEY_LEN(KEY_LEN), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.op(dp_op),
		.in_mode(in_ch.mode),
		.in_key(in_ch.key),
		.in_payload(in_ch.payload),
		.stat(dp_stat),
		.ok(out_ch.ok),
		.result_key(out_ch.result_key),
		.result_payload(out_ch.result_payload),
		.probe_count(out_ch.probe_count)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

	// A taken transaction keeps the block busy on the following cycle.
	`XFTP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	// A result is only loaded while a transaction is in progress.
	`XFTP_ASSERT_NOW(a_emit_while_busy, clk, arst_n, dp_op == OP_EMIT, !in_ch.ready)
	// A failed operation reports no key and no payload.
	`XFTP_ASSERT_NOW(a_fail_zero_fields, clk, arst_n, out_ch.valid && !out_ch.ok,
		out_ch.result_key == '0 && out_ch.result_payload == '0)

endmodule
